/* rtl/key_set_table_assert.svh */
// Assertion macros for the key set table.
// Include by bare file name; expects clk and rst in scope.
`ifndef KEY_SET_TABLE_ASSERT_SVH
`define KEY_SET_TABLE_ASSERT_SVH

// Same-cycle implication, off during reset
`define KST_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("key_set_table: same-cycle check failed");

// Next-cycle implication, off during reset
`define KST_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("key_set_table: next-cycle check failed");

`endif

/* rtl/kst_pkg.sv */
// Shared types and constants for the key set table.
// Used by kst_cell and key_set_table; no dependencies.
package kst_pkg;

  localparam int KEY_W      = 64;
  localparam int KEY_BYTES  = 8;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 5;
  localparam int S_DATA_W   = 64;
  localparam int S_USER_W   = 3;
  localparam int M_DATA_W   = 80;
  localparam int M_USED_W   = CNT_OUT_W + KEY_W + CNT_OUT_W;
  localparam int M_USER_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 3'd0,
    FN_DEL   = 3'd1,
    FN_CLR   = 3'd2,
    FN_ISECT = 3'd3,
    FN_DIFF  = 3'd4
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic scan;
    logic add;
    logic del;
    logic clr;
  } cell_cmd_t;

endpackage

/* rtl/kst_cell.sv */
// One slot of the key set table: stored key, occupancy, scan prefix and count.
// Depends on kst_pkg; chained by key_set_table.
module kst_cell
  import kst_pkg::*;
#(
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [KEY_W-1:0] key,
  input  logic [KEY_W-1:0] up_entry,
  input  logic             up_occ,
  input  logic             low_occ,
  input  logic             pre_in,
  input  logic [CNT_W-1:0] cnt_in,
  output logic [KEY_W-1:0] entry,
  output logic             occ,
  output logic             pre,
  output logic [CNT_W-1:0] cnt
);

  logic match;
  logic take_key;
  logic take_up;

  assign match    = occ && (entry == key);
  assign take_key = cmd.add && !occ && low_occ;
  assign take_up  = cmd.del && pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      pre <= 1'b0;
      cnt <= '0;
    end else begin
      if (cmd.scan) begin
        pre <= pre_in | match;
        cnt <= cnt_in + CNT_W'(match);
      end
      if (cmd.clr) begin
        occ <= 1'b0;
      end else if (take_key) begin
        occ <= 1'b1;
      end else if (take_up) begin
        occ <= up_occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_key) begin
      entry <= key;
    end else if (take_up) begin
      entry <= up_entry;
    end
  end

endmodule

/* rtl/key_set_table.sv */
// Key set table top level: stream ports, sequencer and the chain of kst_cell slots.
// Depends on kst_pkg, kst_cell and key_set_table_assert.svh.
//
//  channel  dir  tdata                                  tuser
//  s_*      in   [63:0] key                             [2:0] func
//  m_*      out  [4:0] match_count, [68:5] out_key,     [1:0] status, [2] emit
//                [73:69] fill_level
//
// Each beat is accepted in IDLE, ripples the match prefix and count through
// the cell chain in SCAN, then updates the table and loads the output register
// in DONE. The next beat is taken once the output is loaded.
// rst clears the table at once. A stalled output holds the table update.
module key_set_table
  import kst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [63:0] key
  input  logic [S_USER_W-1:0] s_tuser,   // [2:0] func
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [4:0] match_count, [68:5] out_key, [73:69] fill_level
  output logic [M_USER_W-1:0] m_tuser    // [1:0] status, [2] emit
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DEPTH);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t              state;
  logic [SW-1:0]       scan_cnt;
  logic [FUNC_W-1:0]   func_r;
  logic [KEY_W-1:0]    key_r;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;

  cell_cmd_t           cmd;
  logic                apply;
  logic                full;
  logic                found;
  logic [CW-1:0]       hit_total;
  logic [STATUS_W-1:0] status;
  logic                emit;
  logic [CNT_OUT_W-1:0] match5;
  logic [CNT_OUT_W-1:0] fill5;
  logic [CW+CNT_OUT_W-1:0] match_ext;
  logic [CW+CNT_OUT_W-1:0] fill_ext;

  logic [KEY_W-1:0]    entry_vec [DEPTH];
  logic [DEPTH-1:0]    occ_vec;
  logic [DEPTH-1:0]    pre_vec;
  logic [CW-1:0]       cnt_vec   [DEPTH];

  function automatic logic [KEY_W-1:0] normalize(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (k[8*i +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = k[8*i +: 8];
      end
    end
    return r;
  endfunction

  assign s_tready  = (state == IDLE) && !rst;
  assign apply     = (state == DONE) && (!m_tvalid || m_tready);
  assign full      = (count == CW'(DEPTH));
  assign found     = pre_vec[DEPTH-1];
  assign hit_total = cnt_vec[DEPTH-1];

  always_comb begin
    cmd        = '0;
    cmd.scan   = (state == SCAN);
    status     = ST_OK;
    emit       = 1'b0;
    count_next = count;
    case (func_r)
      FN_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.add    = apply;
          count_next = count + 1'b1;
        end
      end
      FN_DEL: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          cmd.del    = apply;
          count_next = count - 1'b1;
        end
      end
      FN_CLR: begin
        cmd.clr    = apply;
        count_next = '0;
      end
      FN_ISECT: emit = (hit_total != '0);
      FN_DIFF:  emit = (hit_total == '0);
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign match_ext = {{CNT_OUT_W{1'b0}}, hit_total};
  assign fill_ext  = {{CNT_OUT_W{1'b0}}, count_next};
  assign match5    = match_ext[CNT_OUT_W-1:0];
  assign fill5     = fill_ext[CNT_OUT_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] up_entry;
    logic             up_occ;
    logic             low_occ;
    logic             pre_in;
    logic [CW-1:0]    cnt_in;

    if (i == DEPTH - 1) begin : g_top
      assign up_entry = '0;
      assign up_occ   = 1'b0;
    end else begin : g_mid
      assign up_entry = entry_vec[i+1];
      assign up_occ   = occ_vec[i+1];
    end

    if (i == 0) begin : g_bot
      assign low_occ = 1'b1;
      assign pre_in  = 1'b0;
      assign cnt_in  = '0;
    end else begin : g_rest
      assign low_occ = occ_vec[i-1];
      assign pre_in  = pre_vec[i-1];
      assign cnt_in  = cnt_vec[i-1];
    end

    kst_cell #(
      .CNT_W (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .key      (key_r),
      .up_entry (up_entry),
      .up_occ   (up_occ),
      .low_occ  (low_occ),
      .pre_in   (pre_in),
      .cnt_in   (cnt_in),
      .entry    (entry_vec[i]),
      .occ      (occ_vec[i]),
      .pre      (pre_vec[i]),
      .cnt      (cnt_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      scan_cnt <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (apply) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state    <= SCAN;
            scan_cnt <= '0;
          end
        end
        SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SW'(DEPTH - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (apply) begin
            state <= IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r <= s_tuser[FUNC_W-1:0];
      key_r  <= normalize(s_tdata[KEY_W-1:0]);
    end
    if (apply) begin
      m_tdata <= {{(M_DATA_W - M_USED_W){1'b0}}, fill5, key_r, match5};
      m_tuser <= {emit, status};
    end
  end

  `include "key_set_table_assert.svh"

  `KST_ASSERT_NOW(a_occ_count, 1'b1, ($countones(occ_vec) == 32'(count)))
  `KST_ASSERT_NOW(a_occ_packed, 1'b1, (((occ_vec + 1'b1) & occ_vec) == '0))
  `KST_ASSERT_NEXT(a_del_shrinks, (cmd.del), (count == $past(count) - 1'b1))

endmodule

/* test/key_table_checker.sv */
`timescale 1ns / 1ps
// Reply checker for key_set_table: watches both stream channels, keeps its own key table,
// predicts each reply beat and compares it field by field. Depends on kst_pkg.
module key_table_checker
  import kst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [63:0] key
  input  logic [S_USER_W-1:0] s_tuser,   // [2:0] func
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,   // [4:0] match_count, [68:5] out_key, [73:69] fill_level
  input  logic [M_USER_W-1:0] m_tuser,   // [1:0] status, [2] emit
  output int                  err_count,
  output int                  outstanding,
  output int                  replies_seen,
  output int                  full_replies
);

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 emit;
    logic [CNT_OUT_W-1:0] hits;
    logic [KEY_W-1:0]     key;
    logic [CNT_OUT_W-1:0] fill;
  } reply_t;

  reply_t           reply_q[$];
  logic [KEY_W-1:0] slots[DEPTH];
  int               used;

  // cut at the first zero character and after KEY_BYTES characters
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] r;
    logic [7:0]       ch;
    bit               stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      ch = raw[8*i +: 8];
      if (ch == 8'h00) stop = 1'b1;
      if (!stop) r[8*i +: 8] = ch;
    end
    return r;
  endfunction

  task automatic apply_table_op(input logic [FUNC_W-1:0] code, input logic [KEY_W-1:0] raw);
    reply_t r;
    int     first;
    int     hits;
    r = '0;
    r.key = trim_key(raw);
    first = -1;
    hits = 0;
    for (int i = 0; i < used; i++) begin
      if (slots[i] == r.key) begin
        if (first < 0) first = i;
        hits++;
      end
    end
    case (code)
      FN_ADD: begin
        if (used >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[used] = r.key;
          used++;
        end
      end
      FN_DEL: begin
        if (first < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = first; i < used - 1; i++) slots[i] = slots[i+1];
          slots[used-1] = '0;
          used--;
        end
      end
      FN_CLR: begin
        for (int i = 0; i < DEPTH; i++) slots[i] = '0;
        used = 0;
      end
      FN_ISECT: r.emit = (hits > 0);
      FN_DIFF:  r.emit = (hits == 0);
      default: ;
    endcase
    r.hits = CNT_OUT_W'(hits);
    r.fill = CNT_OUT_W'(used);
    reply_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    err_count++;
    $display("MISMATCH reply %0d %s: got %0h, expected %0h", replies_seen, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      reply_q.delete();
      for (int i = 0; i < DEPTH; i++) slots[i] = '0;
      used = 0;
      err_count = 0;
      replies_seen = 0;
      full_replies = 0;
    end else begin
      if (s_tvalid && s_tready) apply_table_op(s_tuser[FUNC_W-1:0], s_tdata[KEY_W-1:0]);
      if (m_tvalid && m_tready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch("beat with nothing pending", m_tdata[KEY_W-1:0], '0);
        end else begin
          want = reply_q.pop_front();
          if (want.status == ST_FULL) full_replies++;
          if (m_tuser[STATUS_W-1:0] !== want.status)
            report_mismatch("status", m_tuser[STATUS_W-1:0], want.status);
          if (m_tuser[STATUS_W] !== want.emit)
            report_mismatch("emit", m_tuser[STATUS_W], want.emit);
          if (m_tdata[CNT_OUT_W-1:0] !== want.hits)
            report_mismatch("match_count", m_tdata[CNT_OUT_W-1:0], want.hits);
          if (m_tdata[CNT_OUT_W+KEY_W-1:CNT_OUT_W] !== want.key)
            report_mismatch("out_key", m_tdata[CNT_OUT_W+KEY_W-1:CNT_OUT_W], want.key);
          if (m_tdata[M_USED_W-1:CNT_OUT_W+KEY_W] !== want.fill)
            report_mismatch("fill_level", m_tdata[M_USED_W-1:CNT_OUT_W+KEY_W], want.fill);
          if (m_tdata[M_DATA_W-1:M_USED_W] !== '0)
            report_mismatch("tdata padding", m_tdata[M_DATA_W-1:M_USED_W], '0);
        end
      end
    end
    outstanding = reply_q.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top of the key_set_table testbench: clock, reset, command stimulus, output backpressure
// and verdict. Depends on kst_pkg, key_set_table and key_table_checker.
module tb_top;
  import kst_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = DEPTH + 8;
  localparam int POOL_SIZE      = 10;

  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // [63:0] key
  logic [S_USER_W-1:0] s_tuser;   // [2:0] func
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // [4:0] match_count, [68:5] out_key, [73:69] fill_level
  logic [M_USER_W-1:0] m_tuser;   // [1:0] status, [2] emit

  int err_count;
  int pending;
  int replies_seen;
  int full_replies;
  int quiet_cycles;
  int items_sent;
  int op_count[8];
  bit idle_on;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               pool_len[POOL_SIZE];

  key_set_table #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  key_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .err_count    (err_count),
    .outstanding  (pending),
    .replies_seen (replies_seen),
    .full_replies (full_replies)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d replies still pending",
               WATCHDOG_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output side: random stalls plus two long hold-offs that back the block up
  initial begin : sink
    int holds_done;
    holds_done = 0;
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (holds_done < 2 && items_sent >= (holds_done == 0 ? 500 : 1400)) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_beat(input logic [FUNC_W-1:0] code, input logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= code;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    op_count[code]++;
    @(negedge clk);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = (i == 0) ? KEY_BYTES : $urandom_range(0, KEY_BYTES);
      key_pool[i] = '0;
      for (int b = 0; b < pool_len[i]; b++) key_pool[i][8*b +: 8] = $urandom_range(1, 255);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               idx;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 10) return {$urandom, $urandom};
    idx = $urandom_range(POOL_SIZE - 1);
    k = key_pool[idx];
    // garbage past the terminator must not matter
    if (roll < 40 && pool_len[idx] < KEY_BYTES - 1)
      k = k | ({$urandom, $urandom} << (8 * (pool_len[idx] + 1)));
    return k;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input bit filling);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return FN_CLR;
    if (roll < 8) return FUNC_W'(FN_SPARE_A + $urandom_range(0, 2));
    if (roll < (filling ? 50 : 23)) return FN_ADD;
    if (roll < 68) return FN_DEL;
    if (roll < 85) return FN_ISECT;
    return FN_DIFF;
  endfunction

  initial begin : stimulus
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    idle_on = 1'b1;
    items_sent = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(FN_ISECT, '0);
    send_beat(FN_DEL, 64'h41);
    send_beat(FN_ADD, '0);
    send_beat(FN_ADD, '1);
    send_beat(FN_ADD, 64'hDEAD_BEEF_0000_0041);
    send_beat(FN_ADD, 64'h41);
    send_beat(FN_ADD, 64'h4847_4645_4443_4241);
    send_beat(FN_ADD, 64'h5555_5555_5555_5555);
    send_beat(FN_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(FN_ISECT, 64'h1234_0041);
    send_beat(FN_DIFF, 64'h41);
    send_beat(FN_DIFF, 64'h42);
    send_beat(FN_ISECT, 64'hFF00);
    send_beat(FN_DEL, '1);
    send_beat(FN_DEL, 64'h99);
    send_beat(FN_DEL, 64'h41);
    send_beat(FN_SPARE_A, 64'h41);
    send_beat(FN_SPARE_B, '1);
    send_beat(FN_SPARE_C, 64'h7700_0042);
    send_beat(FN_CLR, '1);
    send_beat(FN_ISECT, '1);
    send_beat(FN_DIFF, '1);

    refresh_pool();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 300 == 299) refresh_pool();
      idle_on = !(i >= 900 && i < 1200);
      send_beat(pick_op((i / 100) % 2 == 0), pick_key());
    end
    s_tvalid <= 1'b0;
    idle_on = 1'b1;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d beats: %0d add, %0d delete, %0d clear, %0d intersect, %0d diff, %0d spare",
             items_sent, op_count[FN_ADD], op_count[FN_DEL], op_count[FN_CLR],
             op_count[FN_ISECT], op_count[FN_DIFF],
             op_count[FN_SPARE_A] + op_count[FN_SPARE_B] + op_count[FN_SPARE_C]);
    $display("Checked %0d replies, %0d adds on a full table, %0d mismatches",
             replies_seen, full_replies, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_cell.sv
rtl/key_set_table.sv
test/key_table_checker.sv
test/tb_top.sv
